>>> src/tca_pkg.sv
package tca_pkg;

  localparam int SLOTS   = 8;
  localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = 32;
  localparam int OP_W    = 3;
  localparam int SLOT_W  = 3;
  localparam int DELAY_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_CANCEL = 3'd2,
    OP_QUERY  = 3'd3,
    OP_READ   = 3'd4,
    OP_RESET  = 3'd5
  } tca_op_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_IW-1:0] waddr;
    logic [CNT_W-1:0]   wdata;
    logic               re;
    logic [SLOT_IW-1:0] raddr;
  } tca_ram_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] tick_count;
    logic             done_res;
  } tca_res_t;

endpackage

>>> src/tca_if.sv
interface tca_in_if;
  logic                        valid;
  logic                        ready;
  logic [tca_pkg::OP_W-1:0]    op;
  logic [tca_pkg::SLOT_W-1:0]  slot;
  logic [tca_pkg::DELAY_W-1:0] delay;

  modport source (output valid, output op, output slot, output delay, input ready);
  modport sink   (input valid, input op, input slot, input delay, output ready);
endinterface

interface tca_out_if;
  logic                      valid;
  logic                      ready;
  logic [tca_pkg::CNT_W-1:0] tick_count;
  logic                      done_res;

  modport source (output valid, output tick_count, output done_res, input ready);
  modport sink   (input valid, input tick_count, input done_res, output ready);
endinterface

>>> src/tca_dl_ram.sv
module tca_dl_ram (
  input  logic                      clk,
  input  tca_pkg::tca_ram_req_t     req,
  output logic [tca_pkg::CNT_W-1:0] rdata
);

  logic [tca_pkg::CNT_W-1:0] mem [tca_pkg::SLOTS];
  logic [tca_pkg::CNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/tca_ctrl.sv
module tca_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  tca_in_if.sink                    in_ch,
  output tca_pkg::tca_ram_req_t     ram_req,
  input  logic [tca_pkg::CNT_W-1:0] ram_rdata,
  input  logic                      out_free,
  output logic                      res_valid,
  output tca_pkg::tca_res_t         res
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

  state_t                          st_r, st_nxt;
  logic [tca_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [tca_pkg::SLOTS-1:0]       act_r, act_nxt;
  logic [tca_pkg::SLOTS-1:0]       done_r, done_nxt;
  logic [tca_pkg::SLOT_IW-1:0]     scan_r, scan_nxt;
  logic                            cmp_v_r, cmp_v_nxt;
  logic [tca_pkg::SLOT_IW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                            res_done_r, res_done_nxt;

  logic                            accept;
  logic                            slot_ok;
  logic [tca_pkg::SLOT_IW-1:0]     slot_idx;
  tca_pkg::tca_op_t                op;

  assign accept   = in_ch.valid && (st_r == ST_IDLE);
  assign slot_ok  = 32'(in_ch.slot) < 32'(tca_pkg::SLOTS);
  assign slot_idx = tca_pkg::SLOT_IW'(in_ch.slot);
  assign op       = tca_pkg::tca_op_t'(in_ch.op);

  assign in_ch.ready = (st_r == ST_IDLE);

  always_comb begin
    ram_req.we    = accept && (op == tca_pkg::OP_START) && slot_ok;
    ram_req.waddr = slot_idx;
    ram_req.wdata = cnt_r + tca_pkg::CNT_W'(in_ch.delay);
    ram_req.re    = (st_r == ST_SCAN);
    ram_req.raddr = scan_r;
  end

  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    act_nxt      = act_r;
    done_nxt     = done_r;
    scan_nxt     = scan_r;
    res_done_nxt = res_done_r;
    cmp_v_nxt    = (st_r == ST_SCAN);
    cmp_idx_nxt  = scan_r;
    res_valid    = 1'b0;

    // deadline compare, one slot behind the memory read
    if (cmp_v_r && act_r[cmp_idx_r] && (ram_rdata == cnt_r)) begin
      act_nxt[cmp_idx_r]  = 1'b0;
      done_nxt[cmp_idx_r] = 1'b1;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          res_done_nxt = 1'b0;
          st_nxt       = ST_FIN;
          case (op)
            tca_pkg::OP_TICK: begin
              cnt_nxt  = cnt_r + tca_pkg::CNT_W'(1);
              scan_nxt = '0;
              st_nxt   = ST_SCAN;
            end
            tca_pkg::OP_START: begin
              if (slot_ok) begin
                act_nxt[slot_idx]  = 1'b1;
                done_nxt[slot_idx] = 1'b0;
              end
            end
            tca_pkg::OP_CANCEL: begin
              if (slot_ok) begin
                act_nxt[slot_idx] = 1'b0;
              end
            end
            tca_pkg::OP_QUERY: begin
              res_done_nxt = slot_ok && done_r[slot_idx];
            end
            tca_pkg::OP_RESET: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_r == tca_pkg::SLOT_IW'(tca_pkg::SLOTS - 1)) begin
          st_nxt = ST_FIN;
        end else begin
          scan_nxt = scan_r + tca_pkg::SLOT_IW'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          res_valid = 1'b1;
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      cnt_r   <= '0;
      act_r   <= '0;
      done_r  <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      act_r   <= act_nxt;
      done_r  <= done_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
    scan_r     <= scan_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_done_r <= res_done_nxt;
  end

  assign res.tick_count = cnt_r;
  assign res.done_res   = res_done_r;

endmodule

>>> src/tick_counter_alarm_slots.sv
// Alarm timer with a 32-bit tick counter, advanced by tick operations, and SLOTS alarm slots.
// Each transaction on the input channel yields exactly one result transaction
// carrying the counter after the operation and, for a query, the slot's done
// flag. One item is processed at a time. A tick runs through ST_SCAN before
// its result leaves ST_FIN for the output register: the deadlines sit
// in a synchronous memory and are scanned one entry per cycle.
// All other operations go straight to ST_FIN. A new item is accepted while the
// previous result still waits in the output register.
module tick_counter_alarm_slots (
  input  logic      clk,
  input  logic      rst_n,
  tca_in_if.sink    in_ch,
  tca_out_if.source out_ch
);

  tca_pkg::tca_ram_req_t     ram_req;
  logic [tca_pkg::CNT_W-1:0] ram_rdata;
  logic                      out_free;
  logic                      res_valid;
  tca_pkg::tca_res_t         res;
  logic                      out_valid_r;
  tca_pkg::tca_res_t         out_data_r;

  tca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  tca_dl_ram u_dl_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tick_count = out_data_r.tick_count;
  assign out_ch.done_res   = out_data_r.done_res;

endmodule

>>> src/tca_checker.sv
module tca_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [tca_pkg::OP_W-1:0]  in_op,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [tca_pkg::CNT_W-1:0] out_tick_count
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 2'd3) && (!out_valid || pend_r != 2'd0))
    else $error("result transactions do not match accepted transactions");

  a_reset_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == tca_pkg::OP_RESET) && (pend_r == 2'd0)
    |=> ##1 out_valid && (out_tick_count == '0))
    else $error("reset count result not zero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tick_count))
    else $error("stalled result changed");

endmodule

bind tick_counter_alarm_slots tca_checker u_tca_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_tick_count (out_ch.tick_count)
);

>>> tb/tick_counter_alarm_slots_tb.sv
`timescale 1ns / 100ps

module tick_counter_alarm_slots_tb;

  localparam logic [tca_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [tca_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int          RAND_ITEMS  = 1125;
  localparam int          REPORT_MAX  = 10;

  class alarm_tracker;
    bit [tca_pkg::CNT_W-1:0] count;
    bit [tca_pkg::CNT_W-1:0] deadline [tca_pkg::SLOTS];
    bit                      armed [tca_pkg::SLOTS];
    bit                      fired [tca_pkg::SLOTS];
    tca_pkg::tca_res_t       due_results [$];
    int                      errors;

    function void note_input(logic [tca_pkg::OP_W-1:0] op,
                             logic [tca_pkg::SLOT_W-1:0] slot,
                             logic [tca_pkg::DELAY_W-1:0] delay);
      bit                slot_ok;
      int                idx;
      tca_pkg::tca_res_t res;
      slot_ok = slot < tca_pkg::SLOTS;
      idx = slot_ok ? int'(slot) : 0;
      res.done_res = 1'b0;
      case (tca_pkg::tca_op_t'(op))
        tca_pkg::OP_TICK: begin
          count = count + 1;
          for (int i = 0; i < tca_pkg::SLOTS; i++) begin
            if (armed[i] && deadline[i] == count) begin
              fired[i] = 1'b1;
              armed[i] = 1'b0;
            end
          end
        end
        tca_pkg::OP_START: begin
          if (slot_ok) begin
            deadline[idx] = count + tca_pkg::CNT_W'(delay);
            fired[idx] = 1'b0;
            armed[idx] = 1'b1;
          end
        end
        tca_pkg::OP_CANCEL: begin
          if (slot_ok) armed[idx] = 1'b0;
        end
        tca_pkg::OP_QUERY: begin
          if (slot_ok) res.done_res = fired[idx];
        end
        tca_pkg::OP_RESET: begin
          count = '0;
        end
        default: begin
        end
      endcase
      res.tick_count = count;
      due_results.push_back(res);
    endfunction

    function void check_result(logic [tca_pkg::CNT_W-1:0] tick_count, logic done_res);
      tca_pkg::tca_res_t exp_res;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: tick_count %h done_res %b", tick_count, done_res);
        return;
      end
      exp_res = due_results.pop_front();
      if (tick_count !== exp_res.tick_count || done_res !== exp_res.done_res) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: tick_count exp %h got %h, done_res exp %b got %b",
                   exp_res.tick_count, tick_count, exp_res.done_res, done_res);
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function bit failed();
      return errors != 0 || due_results.size() != 0;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tca_in_if  in_if ();
  tca_out_if out_if ();

  tick_counter_alarm_slots dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  alarm_tracker tracker = new();

  bit tx_eager;
  bit rx_eager;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  int unsigned cycle_cnt;
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tick_counter_alarm_slots verification failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side: checks accepted transactions, drives ready
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready)
        tracker.check_result(out_if.tick_count, out_if.done_res);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 300;
        out_if.ready <= 1'b0;
      end else if (rx_eager) begin
        out_if.ready <= 1'b1;
      end else if ($urandom_range(0, 99) == 0) begin
        stall_left = $urandom_range(15, 50);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  task automatic send_item(input logic [tca_pkg::OP_W-1:0] op,
                           input logic [tca_pkg::SLOT_W-1:0] slot,
                           input logic [tca_pkg::DELAY_W-1:0] delay);
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.slot  <= slot;
    in_if.delay <= delay;
    do @(posedge clk); while (!in_if.ready);
    tracker.note_input(op, slot, delay);
  endtask

  task automatic idle_sender();
    int n;
    n = tx_eager ? 0 : gap_len();
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_paced(input logic [tca_pkg::OP_W-1:0] op,
                            input logic [tca_pkg::SLOT_W-1:0] slot,
                            input logic [tca_pkg::DELAY_W-1:0] delay);
    send_item(op, slot, delay);
    idle_sender();
  endtask

  task automatic send_random_item();
    int                          r;
    logic [tca_pkg::OP_W-1:0]    op;
    logic [tca_pkg::DELAY_W-1:0] delay;
    r = $urandom_range(0, 99);
    if (r < 40)      op = tca_pkg::OP_TICK;
    else if (r < 60) op = tca_pkg::OP_START;
    else if (r < 68) op = tca_pkg::OP_CANCEL;
    else if (r < 88) op = tca_pkg::OP_QUERY;
    else if (r < 94) op = tca_pkg::OP_READ;
    else if (r < 96) op = tca_pkg::OP_RESET;
    else             op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
    r = $urandom_range(0, 99);
    if (r < 70)      delay = tca_pkg::DELAY_W'($urandom_range(0, 24));
    else if (r < 85) delay = tca_pkg::DELAY_W'($urandom_range(25, 300));
    else             delay = tca_pkg::DELAY_W'($urandom_range(0, 65535));
    send_item(op, tca_pkg::SLOT_W'($urandom_range(0, tca_pkg::SLOTS - 1)), delay);
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.op    <= tca_pkg::OP_READ;
    in_if.slot  <= '0;
    in_if.delay <= '0;
    tx_eager = 1'b0;
    rx_eager = 1'b0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_paced(tca_pkg::OP_READ,   3'd0, 16'h0000);
    send_paced(tca_pkg::OP_QUERY,  3'd0, 16'h0000);
    send_paced(tca_pkg::OP_START,  3'd0, 16'd1);
    send_paced(tca_pkg::OP_START,  3'd7, 16'h0000);    // zero delay: waits a full wrap
    send_paced(tca_pkg::OP_START,  3'd1, 16'hFFFF);
    send_paced(tca_pkg::OP_START,  3'd2, 16'd3);
    send_paced(tca_pkg::OP_START,  3'd3, 16'd2);
    send_paced(tca_pkg::OP_START,  3'd3, 16'd5);       // re-arm overrides
    send_paced(tca_pkg::OP_CANCEL, 3'd4, 16'hFFFF);    // inactive slot
    send_paced(tca_pkg::OP_TICK,   3'd0, 16'h0000);
    send_paced(tca_pkg::OP_QUERY,  3'd0, 16'h0000);
    send_paced(tca_pkg::OP_TICK,   3'd5, 16'h5555);
    send_paced(tca_pkg::OP_QUERY,  3'd3, 16'h0000);
    send_paced(tca_pkg::OP_TICK,   3'd2, 16'hAAAA);
    send_paced(tca_pkg::OP_CANCEL, 3'd2, 16'h0000);    // done survives cancel
    send_paced(tca_pkg::OP_QUERY,  3'd2, 16'h0000);
    send_paced(tca_pkg::OP_CANCEL, 3'd3, 16'h0000);
    send_paced(tca_pkg::OP_TICK,   3'd0, 16'h0000);
    send_paced(tca_pkg::OP_TICK,   3'd0, 16'h0000);
    send_paced(tca_pkg::OP_QUERY,  3'd3, 16'h0000);
    send_paced(tca_pkg::OP_QUERY,  3'd7, 16'h0000);
    send_paced(OP_SPARE6,          3'd7, 16'hFFFF);
    send_paced(OP_SPARE7,          3'd1, 16'h0000);
    send_paced(tca_pkg::OP_RESET,  3'd6, 16'h1234);
    send_paced(tca_pkg::OP_START,  3'd6, 16'd1);
    send_paced(tca_pkg::OP_TICK,   3'd0, 16'h0000);
    send_paced(tca_pkg::OP_QUERY,  3'd6, 16'h0000);

    // random
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 300) hold_req = 1'b1;
      if (i == 700) begin
        tx_eager = 1'b1;
        rx_eager = 1'b1;
      end
      if (i == 900) begin
        tx_eager = 1'b0;
        rx_eager = 1'b0;
      end
      send_random_item();
      if (i == 600) begin
        in_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
      end else if (i != RAND_ITEMS - 1) begin
        idle_sender();
      end
    end
    in_if.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (2 * tca_pkg::SLOTS + 10) @(posedge clk);
    if (tracker.failed()) begin
      $display("tick_counter_alarm_slots verification failed");
    end else begin
      $display("tick_counter_alarm_slots verification clean");
    end
    $finish;
  end

endmodule
